[hw/rtl/wced_pkg.sv]
// wced_pkg: shared types, constants and helpers for the window operator.
// Used by window_convolve_erode_dilate, wced_front and wced_back. No dependencies.
`timescale 1ns / 1ps
package wced_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int MAX_KERNEL_DEF  = 8;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Kernel tap layout and result width
  localparam int TAP_STRIDE = 8;
  localparam int TAP_COUNT  = 64;
  localparam int VALUE_BITS = 38;
  localparam int COL_BITS   = 13;  // enough for any column up to 8191
  // Starting point of the erode minimum: largest 32-bit signed value
  localparam logic signed [31:0] ERODE_START = 32'sh7fff_ffff;

  // Queue depths (powers of two)
  localparam int IQ_DEPTH = 4;
  localparam int OQ_DEPTH = 16;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_WIDTH  = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_MODE          = 3'd4
  } cfg_reg_t;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_SUM    = 2'd0,
    MODE_ERODE  = 2'd1,
    MODE_DILATE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Input actions
  localparam logic ACT_COEF  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // Kernel geometry after clamping, plus mode
  typedef struct packed {
    logic [3:0] kw;
    logic [3:0] kh;
    mode_t      mode;
  } geom_t;

  // Classified transaction, front to back
  typedef struct packed {
    logic                is_pixel;
    logic                emit;
    logic [15:0]         pixel;
    logic [5:0]          tap_index;
    logic [15:0]         tap_value;
    logic [COL_BITS-1:0] col;
    logic [9:0]          centre_col;
    logic [15:0]         centre_row;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [9:0]            centre_col;
    logic [15:0]           centre_row;
    logic [VALUE_BITS-1:0] value;
  } res_t;

  // Minimum or maximum of two signed values
  function automatic logic signed [31:0] min_max(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic is_min);
    if (is_min) return (a < b) ? a : b;
    return (a > b) ? a : b;
  endfunction

endpackage

[hw/rtl/window_convolve_erode_dilate.sv]
// window_convolve_erode_dilate: top level with configuration registers.
// Depends on wced_pkg, wced_front, wced_fifo, wced_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in_      | in_valid / in_stall  | action, tap_index, tap_value, pixel
//  out_     | out_valid / out_stall| centre_col, centre_row, value
//  cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction per clock sustained while out_stall is low. A result passes
// through the input queue, line store read, window shift, tap multiply, a
// registered reduction tree and the result queue before out_valid rises for it.
// Reset is synchronous, active low; line stores and window are not cleared.
// A stall on out_ fills the 16-entry result queue, then the 4-entry input
// queue, then raises in_stall.
`timescale 1ns / 1ps
module window_convolve_erode_dilate import wced_pkg::*; #(
  parameter int MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [5:0]  in_tap_index,
  input  logic [15:0] in_tap_value,
  input  logic [15:0] in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_centre_col,
  output logic [15:0] out_centre_row,
  output logic [37:0] out_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int KL = (MAX_KERNEL < TAP_STRIDE) ? MAX_KERNEL : TAP_STRIDE;

  logic [10:0] image_width_r;
  logic [15:0] image_height_r;
  logic [3:0]  kernel_width_r, kernel_height_r;
  logic [1:0]  mode_r;
  geom_t       geom;
  item_t       fq_item, bq_item;
  logic        fq_push, q_full, q_empty, q_pop;
  logic [$clog2(IQ_DEPTH+1)-1:0] q_count;
  res_t        res;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 11'd1024;
      image_height_r  <= 16'd1024;
      kernel_width_r  <= 4'd3;
      kernel_height_r <= 4'd3;
      mode_r          <= MODE_SUM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data;
        REG_KERNEL_WIDTH:  kernel_width_r  <= cfg_data[3:0];
        REG_KERNEL_HEIGHT: kernel_height_r <= cfg_data[3:0];
        REG_MODE:          mode_r          <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Kernel sizes held to 1..KL
  always_comb begin
    if (kernel_width_r == '0) geom.kw = 4'd1;
    else if (32'(kernel_width_r) > KL) geom.kw = 4'(KL);
    else geom.kw = kernel_width_r;
    if (kernel_height_r == '0) geom.kh = 4'd1;
    else if (32'(kernel_height_r) > KL) geom.kh = 4'(KL);
    else geom.kh = kernel_height_r;
    geom.mode = mode_t'(mode_r);
  end

  wced_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_tap_index (in_tap_index),
    .in_tap_value (in_tap_value),
    .in_pixel     (in_pixel),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .geom         (geom),
    .q_full       (q_full),
    .q_push       (fq_push),
    .q_item       (fq_item)
  );

  wced_fifo #(.WIDTH($bits(item_t)), .DEPTH(IQ_DEPTH)) u_iq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_item),
    .pop   (q_pop),
    .dout  (bq_item),
    .count (q_count),
    .full  (q_full),
    .empty (q_empty)
  );

  wced_back #(
    .MAX_KERNEL  (MAX_KERNEL),
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .q_item    (bq_item),
    .q_empty   (q_empty && (q_count == '0)),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_centre_col = res.centre_col;
  assign out_centre_row = res.centre_row;
  assign out_value      = res.value;

endmodule

[hw/rtl/wced_ram.sv]
// wced_ram: generic single-write, single-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module wced_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/wced_fifo.sv]
// wced_fifo: small register queue with occupancy count.
// Depends on nothing; DEPTH must be a power of two.
`timescale 1ns / 1ps
module wced_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign dout  = mem_r[rd_r];
  assign count = cnt_r;
  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

  // Pointer and count update
  always_comb begin
    wr_nxt  = push ? wr_r + AW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + AW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

[hw/rtl/wced_front.sv]
// wced_front: accepts input transactions, keeps the raster counters and
// classifies each one for the back end. Depends on wced_pkg.
`timescale 1ns / 1ps
module wced_front import wced_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [5:0]  in_tap_index,
  input  logic [15:0] in_tap_value,
  input  logic [15:0] in_pixel,
  input  logic [10:0] image_width,
  input  logic [15:0] image_height,
  input  geom_t       geom,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [31:0]   w32, h32, col32, row32;
  logic          accept, is_pixel;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_pixel = (in_action == ACT_PIXEL);
  assign q_push   = accept;
  assign col32    = 32'(col_r);
  assign row32    = 32'(row_r);

  // Clamped image sizes
  always_comb begin
    if (image_width == '0) w32 = 32'd1;
    else if (32'(image_width) > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    else w32 = 32'(image_width);
    h32 = (image_height == '0) ? 32'd1 : 32'(image_height);
  end

  // Classification: full window and centre position
  always_comb begin
    q_item            = '0;
    q_item.is_pixel   = is_pixel;
    q_item.emit       = is_pixel && (col32 + 32'd1 >= 32'(geom.kw))
                        && (row32 + 32'd1 >= 32'(geom.kh));
    q_item.pixel      = in_pixel;
    q_item.tap_index  = in_tap_index;
    q_item.tap_value  = in_tap_value;
    q_item.col        = COL_BITS'(col_r);
    q_item.centre_col = 10'(col32 - 32'(geom.kw[3:1]));
    q_item.centre_row = row_r - 16'(geom.kh[3:1]);
  end

  // Raster counters, moved only by samples
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && is_pixel) begin
      if (col32 + 32'd1 >= w32) begin
        col_nxt = '0;
        row_nxt = (row32 + 32'd1 >= h32) ? 16'd0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[hw/rtl/wced_back.sv]
// wced_back: line stores, window, coefficient bank, tap arithmetic and
// result queue. Depends on wced_pkg, wced_ram and wced_fifo.
`timescale 1ns / 1ps
module wced_back import wced_pkg::*; #(
  parameter int MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  geom_t       geom,
  input  item_t       q_item,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_res
);

  localparam int KL  = (MAX_KERNEL < TAP_STRIDE) ? MAX_KERNEL : TAP_STRIDE;
  localparam int KIW = (KL > 1) ? $clog2(KL) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int SB  = SAMPLE_BITS;
  localparam int PW  = SB + 16;
  localparam int VB  = VALUE_BITS;
  localparam int OCW = $clog2(OQ_DEPTH + 1);

  // ---------------- issue: pop and line store read ----------------
  logic           credit_ok, re, fwd_r, fwd_nxt;
  logic [OCW-1:0] ocount, inflight_r, inflight_nxt;
  logic           oq_push, oq_empty, oq_full;
  item_t          s1_r;
  logic           s1_v_r;

  assign credit_ok = (32'(ocount) + 32'(inflight_r)) < 32'(OQ_DEPTH);
  assign q_pop     = !q_empty && (!q_item.emit || credit_ok);
  assign re        = q_pop && q_item.is_pixel;
  // Read and write of the same column in one cycle: take the written data
  assign fwd_nxt   = s1_v_r && s1_r.is_pixel && (s1_r.col[CW-1:0] == q_item.col[CW-1:0]);

  always_comb begin
    inflight_nxt = inflight_r;
    if ((q_pop && q_item.emit) && !oq_push) inflight_nxt = inflight_r + OCW'(1);
    else if (!(q_pop && q_item.emit) && oq_push) inflight_nxt = inflight_r - OCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      inflight_r <= '0;
    end else begin
      s1_v_r     <= q_pop;
      inflight_r <= inflight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r  <= q_item;
      fwd_r <= fwd_nxt;
    end
  end

  // ---------------- window update ----------------
  logic signed [SB-1:0] samp;
  logic signed [SB-1:0] colvec [KL];
  logic signed [SB-1:0] window_r [KL][KL];
  logic signed [15:0]   coef_r [TAP_COUNT];
  logic                 wr_pix, wr_coef;

  assign wr_pix  = s1_v_r && s1_r.is_pixel;
  assign wr_coef = s1_v_r && !s1_r.is_pixel;

  generate
    if (SB >= 16) begin : g_wide
      assign samp = SB'($signed(s1_r.pixel));
    end else begin : g_narrow
      assign samp = s1_r.pixel[SB-1:0];
    end
  endgenerate

  assign colvec[0] = samp;

  // Line stores: one RAM per stored row, each row ages into the next
  generate
    if (KL > 1) begin : g_lines
      logic [SB-1:0] ram_q  [KL-1];
      logic [SB-1:0] last_r [KL-1];
      for (genvar d = 0; d < KL - 1; d++) begin : g_row
        wced_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_line (
          .clk   (clk),
          .we    (wr_pix),
          .waddr (s1_r.col[CW-1:0]),
          .wdata (colvec[d]),
          .re    (re),
          .raddr (q_item.col[CW-1:0]),
          .rdata (ram_q[d])
        );
        assign colvec[d+1] = fwd_r ? last_r[d] : ram_q[d];
        always_ff @(posedge clk) begin
          if (wr_pix) begin
            last_r[d] <= colvec[d];
          end
        end
      end
    end
  endgenerate

  // Window shift: column age grows to the right
  always_ff @(posedge clk) begin
    if (wr_pix) begin
      for (int d = 0; d < KL; d++) begin
        for (int a = KL - 1; a >= 1; a--) begin
          window_r[d][a] <= window_r[d][a-1];
        end
        window_r[d][0] <= colvec[d];
      end
    end
  end

  // Coefficient bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TAP_COUNT; t++) coef_r[t] <= '0;
    end else if (wr_coef) begin
      coef_r[s1_r.tap_index] <= $signed(s1_r.tap_value);
    end
  end

  // ---------------- tap lanes ----------------
  logic        s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [9:0]  cc2_r, cc3_r, cc4_r, cc5_r;
  logic [15:0] cr2_r, cr3_r, cr4_r, cr5_r;
  logic        is_min;
  logic signed [VB-1:0] prod_c [TAP_COUNT];
  logic signed [31:0]   mm_c   [TAP_COUNT];
  logic signed [VB-1:0] prod_r [TAP_COUNT];
  logic signed [31:0]   mm_r   [TAP_COUNT];
  logic signed [31:0]   mm_init;

  assign is_min  = (geom.mode == MODE_ERODE);
  assign mm_init = is_min ? ERODE_START : 32'sd0;

  generate
    for (genvar i = 0; i < TAP_STRIDE; i++) begin : g_ti
      for (genvar j = 0; j < TAP_STRIDE; j++) begin : g_tj
        if (i < KL && j < KL) begin : g_live
          logic                 use_tap, pos;
          logic [3:0]           ri, cj;
          logic signed [SB-1:0] s;
          logic signed [PW-1:0] p;
          assign use_tap = (4'(i) < geom.kh) && (4'(j) < geom.kw);
          assign ri      = use_tap ? geom.kh - 4'(i + 1) : 4'd0;
          assign cj      = use_tap ? geom.kw - 4'(j + 1) : 4'd0;
          assign s       = window_r[ri[KIW-1:0]][cj[KIW-1:0]];
          assign p       = coef_r[i*TAP_STRIDE+j] * s;
          assign pos     = use_tap && (coef_r[i*TAP_STRIDE+j] > 16'sd0);
          assign prod_c[i*TAP_STRIDE+j] = use_tap ? VB'(p) : '0;
          assign mm_c[i*TAP_STRIDE+j]   = pos ? 32'(s) : mm_init;
        end else begin : g_dead
          assign prod_c[i*TAP_STRIDE+j] = '0;
          assign mm_c[i*TAP_STRIDE+j]   = mm_init;
        end
      end
    end
  endgenerate

  // ---------------- reduction tree ----------------
  logic signed [VB-1:0] sum16_r [16];
  logic signed [31:0]   mm16_r  [16];
  logic signed [VB-1:0] sum4_r  [4];
  logic signed [31:0]   mm4_r   [4];
  logic signed [VB-1:0] sum_fin;
  logic signed [31:0]   mm_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_r.is_pixel && s1_r.emit;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    cc2_r <= s1_r.centre_col;
    cr2_r <= s1_r.centre_row;
    cc3_r <= cc2_r;
    cr3_r <= cr2_r;
    cc4_r <= cc3_r;
    cr4_r <= cr3_r;
    cc5_r <= cc4_r;
    cr5_r <= cr4_r;
    for (int t = 0; t < TAP_COUNT; t++) begin
      prod_r[t] <= prod_c[t];
      mm_r[t]   <= mm_c[t];
    end
    for (int g = 0; g < 16; g++) begin
      sum16_r[g] <= prod_r[4*g] + prod_r[4*g+1] + prod_r[4*g+2] + prod_r[4*g+3];
      mm16_r[g]  <= min_max(min_max(mm_r[4*g], mm_r[4*g+1], is_min),
                            min_max(mm_r[4*g+2], mm_r[4*g+3], is_min), is_min);
    end
    for (int g = 0; g < 4; g++) begin
      sum4_r[g] <= sum16_r[4*g] + sum16_r[4*g+1] + sum16_r[4*g+2] + sum16_r[4*g+3];
      mm4_r[g]  <= min_max(min_max(mm16_r[4*g], mm16_r[4*g+1], is_min),
                           min_max(mm16_r[4*g+2], mm16_r[4*g+3], is_min), is_min);
    end
  end

  assign sum_fin = sum4_r[0] + sum4_r[1] + sum4_r[2] + sum4_r[3];
  assign mm_fin  = min_max(min_max(mm4_r[0], mm4_r[1], is_min),
                           min_max(mm4_r[2], mm4_r[3], is_min), is_min);

  // ---------------- result queue ----------------
  res_t oq_din;
  logic oq_pop;

  assign oq_push = s5_v_r;
  assign oq_pop  = !oq_empty && !out_stall;

  always_comb begin
    oq_din.centre_col = cc5_r;
    oq_din.centre_row = cr5_r;
    case (geom.mode)
      MODE_SUM:    oq_din.value = sum_fin;
      MODE_ERODE:  oq_din.value = VB'(mm_fin);
      MODE_DILATE: oq_din.value = VB'(mm_fin);
      default:     oq_din.value = '0;
    endcase
  end

  wced_fifo #(.WIDTH($bits(res_t)), .DEPTH(OQ_DEPTH)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_din),
    .pop   (oq_pop),
    .dout  (out_res),
    .count (ocount),
    .full  (oq_full),
    .empty (oq_empty)
  );

  assign out_valid = !oq_empty && !oq_full | !oq_empty;

endmodule

[hw/rtl/wced_chk.sv]
// wced_chk: port-level checks for window_convolve_erode_dilate, bound in.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
module wced_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_centre_col,
  input logic [15:0] out_centre_row,
  input logic [37:0] out_value,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // Queues come up empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // Input side free after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_value)
      && $stable(out_centre_col) && $stable(out_centre_row))
    else $error("stalled result changed");

endmodule

bind window_convolve_erode_dilate wced_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_centre_col (out_centre_col),
  .out_centre_row (out_centre_row),
  .out_value      (out_value),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
